/* src/assert_macros.svh */
// Assertion helpers for the pump controller RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define HDP_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is low.
`define HDP_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* src/hdp_pkg.sv */
`default_nettype none
package hdp_pkg;
    localparam int DEF_ZONE_SLOTS = 16;
    localparam int ID_W           = 8;
    localparam int DEM_W          = 8;
    localparam int CFG_IDX_W      = 2;
    localparam int CFG_DATA_W     = 8;

    localparam logic [ID_W-1:0]       FREE_ID     = 8'd255;
    localparam logic [CFG_DATA_W-1:0] ON_RESET    = 8'd50;
    localparam logic [CFG_DATA_W-1:0] OFF_RESET   = 8'd20;
    localparam logic [CFG_DATA_W-1:0] GROUP_RESET = 8'd0;

    localparam logic [CFG_IDX_W-1:0] CFG_ON_THRESHOLD  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OFF_THRESHOLD = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PUMP_GROUP    = 2'd2;
endpackage
`default_nettype wire

/* src/hdp_if.sv */
`default_nettype none
interface hdp_in_if;
    logic                      valid;
    logic                      ready;
    logic                      is_demand_report;
    logic [hdp_pkg::ID_W-1:0]  zone_id;
    logic [hdp_pkg::DEM_W-1:0] demand;
    modport source (output valid, is_demand_report, zone_id, demand, input ready);
    modport sink (input valid, is_demand_report, zone_id, demand, output ready);
endinterface

interface hdp_out_if;
    logic                           valid;
    logic                           ready;
    logic                           pump_on;
    logic [hdp_pkg::CFG_DATA_W-1:0] group_number;
    modport source (output valid, pump_on, group_number, input ready);
    modport sink (input valid, pump_on, group_number, output ready);
endinterface

interface hdp_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [hdp_pkg::CFG_IDX_W-1:0]  index;
    logic [hdp_pkg::CFG_DATA_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

/* src/hdp_ram.sv */
`default_nettype none
module hdp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = hdp_pkg::DEF_ZONE_SLOTS
) (
    input  wire logic                                    i_clk,
    input  wire logic                                    i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                        i_wdata,
    input  wire logic                                    i_re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                        o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule
`default_nettype wire

/* src/heat_demand_pump_hysteresis.sv */
// Channel | Dir | Words
// i_cfg   | in  | index, data: threshold and group writes, always ready
// i_in    | in  | is_demand_report, zone_id, demand
// o_out   | out | pump_on, group_number: zero or one word per report
//
// A report is accepted only while idle; the next one waits until the decision on the
// last one is made and its result word, if any, is registered on o_out.
// The table walk reads the zone RAM one slot a cycle, then a restoring divider
// produces one quotient bit a cycle over the SUM_W bits of the demand sum.
// Ignored words are taken in idle. Reset is synchronous and empties the table at once.
// A result waiting on o_out stalls only a decision that sends a word, not the scan.
`default_nettype none
`include "assert_macros.svh"
module heat_demand_pump_hysteresis #(
    parameter int ZONE_SLOTS = hdp_pkg::DEF_ZONE_SLOTS
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    hdp_cfg_if.sink    i_cfg,
    hdp_in_if.sink     i_in,
    hdp_out_if.source  o_out
);
    import hdp_pkg::*;

    localparam int AW    = (ZONE_SLOTS > 1) ? $clog2(ZONE_SLOTS) : 1;
    localparam int NZ_W  = $clog2(ZONE_SLOTS + 1);
    localparam int SUM_W = $clog2(ZONE_SLOTS * 255 + 1);
    localparam int DS_W  = $clog2(SUM_W + 1);
    localparam int ENT_W = ID_W + DEM_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_UPDATE,
        S_DIV,
        S_DECIDE
    } t_state;

    t_state                r_state, n_state;
    logic [ZONE_SLOTS-1:0] r_valid, n_valid;
    logic [NZ_W-1:0]       r_cnt, n_cnt;
    logic                  r_pend, n_pend;
    logic                  r_pvalid, n_pvalid;
    logic [AW-1:0]         r_paddr, n_paddr;
    logic [ID_W-1:0]       r_id, n_id;
    logic [DEM_W-1:0]      r_val, n_val;
    logic                  r_hit, n_hit;
    logic [AW-1:0]         r_hit_idx, n_hit_idx;
    logic [DEM_W-1:0]      r_old, n_old;
    logic                  r_free, n_free;
    logic [AW-1:0]         r_free_idx, n_free_idx;
    logic [SUM_W-1:0]      r_sum, n_sum;
    logic [NZ_W-1:0]       r_nz, n_nz;
    logic [NZ_W-1:0]       r_rem, n_rem;
    logic [SUM_W-1:0]      r_quo, n_quo;
    logic [DS_W-1:0]       r_dstep, n_dstep;
    logic [7:0]            r_on, r_off, r_group;
    logic                  r_out_valid, n_out_valid;
    logic                  r_out_on, n_out_on;
    logic [7:0]            r_out_group, n_out_group;

    logic             w_re, w_we;
    logic [AW-1:0]    w_waddr;
    logic [ENT_W-1:0] w_rdata;
    logic [ID_W-1:0]  w_eid;
    logic [DEM_W-1:0] w_edem;
    logic [NZ_W:0]    w_trial;
    logic             w_ge;
    logic [7:0]       w_avg;
    logic             w_out_free;

    hdp_ram #(.WIDTH(ENT_W), .DEPTH(ZONE_SLOTS)) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata ({r_id, r_val}),
        .i_re    (w_re),
        .i_raddr (r_cnt[AW-1:0]),
        .o_rdata (w_rdata)
    );

    assign i_cfg.ready        = 1'b1;
    assign i_in.ready         = (r_state == S_IDLE);
    assign o_out.valid        = r_out_valid;
    assign o_out.pump_on      = r_out_on;
    assign o_out.group_number = r_out_group;

    assign w_re       = (r_state == S_SCAN) && (r_cnt != NZ_W'(ZONE_SLOTS));
    assign w_we       = (r_state == S_UPDATE) && (r_hit || r_free);
    assign w_waddr    = r_hit ? r_hit_idx : r_free_idx;
    assign w_eid      = r_pvalid ? w_rdata[ENT_W-1:DEM_W] : FREE_ID;
    assign w_edem     = r_pvalid ? w_rdata[DEM_W-1:0] : '0;
    assign w_trial    = {r_rem, r_quo[SUM_W-1]};
    assign w_ge       = (w_trial >= {1'b0, r_nz});
    assign w_avg      = (r_nz == '0) ? 8'd0 : r_quo[7:0];
    assign w_out_free = !r_out_valid || o_out.ready;

    always_comb begin
        n_state     = r_state;
        n_valid     = r_valid;
        n_cnt       = r_cnt;
        n_pend      = 1'b0;
        n_pvalid    = r_pvalid;
        n_paddr     = r_paddr;
        n_id        = r_id;
        n_val       = r_val;
        n_hit       = r_hit;
        n_hit_idx   = r_hit_idx;
        n_old       = r_old;
        n_free      = r_free;
        n_free_idx  = r_free_idx;
        n_sum       = r_sum;
        n_nz        = r_nz;
        n_rem       = r_rem;
        n_quo       = r_quo;
        n_dstep     = r_dstep;
        n_out_valid = r_out_valid;
        n_out_on    = r_out_on;
        n_out_group = r_out_group;

        if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_in.valid && i_in.is_demand_report && (i_in.zone_id != FREE_ID)) begin
                    n_id    = i_in.zone_id;
                    n_val   = i_in.demand;
                    n_cnt   = '0;
                    n_hit   = 1'b0;
                    n_free  = 1'b0;
                    n_sum   = '0;
                    n_nz    = '0;
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (w_re) begin
                    n_cnt    = r_cnt + NZ_W'(1);
                    n_pend   = 1'b1;
                    n_paddr  = r_cnt[AW-1:0];
                    n_pvalid = r_valid[r_cnt[AW-1:0]];
                end else begin
                    n_state = S_UPDATE;
                end
                if (r_pend) begin
                    if ((w_eid == r_id) && !r_hit) begin
                        n_hit     = 1'b1;
                        n_hit_idx = r_paddr;
                        n_old     = w_edem;
                    end
                    if ((w_eid == FREE_ID) && !r_free) begin
                        n_free     = 1'b1;
                        n_free_idx = r_paddr;
                    end
                    if (w_edem != '0) begin
                        n_sum = r_sum + SUM_W'(w_edem);
                        n_nz  = r_nz + NZ_W'(1);
                    end
                end
            end
            S_UPDATE: begin
                if (r_hit) begin
                    n_sum = r_sum - SUM_W'(r_old) + SUM_W'(r_val);
                    n_nz  = r_nz - NZ_W'(r_old != '0) + NZ_W'(r_val != '0);
                end else if (r_free) begin
                    n_sum = r_sum + SUM_W'(r_val);
                    n_nz  = r_nz + NZ_W'(r_val != '0);
                end
                if (w_we) begin
                    n_valid[w_waddr] = 1'b1;
                end
                n_rem   = '0;
                n_quo   = n_sum;
                n_dstep = DS_W'(SUM_W);
                n_state = S_DIV;
            end
            S_DIV: begin
                n_quo = {r_quo[SUM_W-2:0], w_ge};
                if (w_ge) begin
                    n_rem = NZ_W'(w_trial - {1'b0, r_nz});
                end else begin
                    n_rem = w_trial[NZ_W-1:0];
                end
                n_dstep = r_dstep - DS_W'(1);
                if (r_dstep == DS_W'(1)) begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (w_avg >= r_on) begin
                    if (w_out_free) begin
                        n_out_valid = 1'b1;
                        n_out_on    = 1'b1;
                        n_out_group = r_group;
                        n_state     = S_IDLE;
                    end
                end else if (w_avg <= r_off) begin
                    if (w_out_free) begin
                        n_out_valid = 1'b1;
                        n_out_on    = 1'b0;
                        n_out_group = r_group;
                        n_state     = S_IDLE;
                    end
                end else begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_valid     <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
            r_on        <= ON_RESET;
            r_off       <= OFF_RESET;
            r_group     <= GROUP_RESET;
        end else begin
            r_state     <= n_state;
            r_valid     <= n_valid;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
            if (i_cfg.valid) begin
                case (i_cfg.index)
                    CFG_ON_THRESHOLD:  r_on    <= i_cfg.data;
                    CFG_OFF_THRESHOLD: r_off   <= i_cfg.data;
                    CFG_PUMP_GROUP:    r_group <= i_cfg.data;
                    default: begin
                    end
                endcase
            end
        end
        r_cnt       <= n_cnt;
        r_pvalid    <= n_pvalid;
        r_paddr     <= n_paddr;
        r_id        <= n_id;
        r_val       <= n_val;
        r_hit       <= n_hit;
        r_hit_idx   <= n_hit_idx;
        r_old       <= n_old;
        r_free      <= n_free;
        r_free_idx  <= n_free_idx;
        r_sum       <= n_sum;
        r_nz        <= n_nz;
        r_rem       <= n_rem;
        r_quo       <= n_quo;
        r_dstep     <= n_dstep;
        r_out_on    <= n_out_on;
        r_out_group <= n_out_group;
    end

    `HDP_ASSERT_IMP(a_write_in_update, i_clk, i_rst_n, w_we, r_state == S_UPDATE)
    `HDP_ASSERT_NXT(a_report_starts_scan, i_clk, i_rst_n,
        i_in.valid && i_in.ready && i_in.is_demand_report && (i_in.zone_id != FREE_ID),
        r_state == S_SCAN)
    `HDP_ASSERT_IMP(a_rem_below_count, i_clk, i_rst_n,
        (r_state == S_DIV) && (r_nz != '0), r_rem < r_nz)
    `HDP_ASSERT_NXT(a_result_from_decide, i_clk, i_rst_n,
        !r_out_valid && (r_state != S_DECIDE), !r_out_valid)
endmodule
`default_nettype wire

/* verif/tb_heat_demand_pump_hysteresis.sv */
`timescale 1ns / 1ps
module tb_heat_demand_pump_hysteresis;
    import hdp_pkg::*;

    localparam int ZONES = DEF_ZONE_SLOTS;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
    localparam int LATENCY_PAD = 40;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int ITEMS_PER_PHASE = 225;
    localparam int PHASES = 6;

    typedef struct packed {
        logic                  pump_on;
        logic [CFG_DATA_W-1:0] grp_num;
    } t_pump_cmd;

    class pump_command_tracker;
        logic [CFG_DATA_W-1:0] on_level;
        logic [CFG_DATA_W-1:0] off_level;
        logic [CFG_DATA_W-1:0] grp_num;
        logic [ID_W-1:0]       slot_id [ZONES];
        logic [DEM_W-1:0]      slot_demand [ZONES];
        t_pump_cmd             pending_cmds [$];
        int                    errors;

        function new();
            on_level = ON_RESET;
            off_level = OFF_RESET;
            grp_num = GROUP_RESET;
            foreach (slot_id[n]) begin
                slot_id[n] = FREE_ID;
                slot_demand[n] = '0;
            end
            errors = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_ON_THRESHOLD: on_level = data;
                CFG_OFF_THRESHOLD: off_level = data;
                CFG_PUMP_GROUP: grp_num = data;
                default: ;
            endcase
        endfunction

        function void absorb_report(logic is_report, logic [ID_W-1:0] id,
                                    logic [DEM_W-1:0] dem);
            int hit;
            int sum;
            int count;
            logic [DEM_W-1:0] mean;
            t_pump_cmd cmd;
            if (!is_report || id == FREE_ID) return;
            hit = -1;
            for (int n = 0; n < ZONES; n++) begin
                if (hit < 0 && slot_id[n] == id) hit = n;
            end
            for (int n = 0; n < ZONES; n++) begin
                if (hit < 0 && slot_id[n] == FREE_ID) begin
                    hit = n;
                    slot_id[n] = id;
                end
            end
            if (hit >= 0) slot_demand[hit] = dem;
            sum = 0;
            count = 0;
            for (int n = 0; n < ZONES; n++) begin
                if (slot_demand[n] != 0) begin
                    sum += slot_demand[n];
                    count++;
                end
            end
            mean = (count == 0) ? '0 : DEM_W'(sum / count);
            cmd.grp_num = grp_num;
            if (mean >= on_level) begin
                cmd.pump_on = 1'b1;
                pending_cmds.push_back(cmd);
            end else if (mean <= off_level) begin
                cmd.pump_on = 1'b0;
                pending_cmds.push_back(cmd);
            end
        endfunction

        function void match_command(logic pump_on, logic [CFG_DATA_W-1:0] grp);
            t_pump_cmd want;
            if (pending_cmds.size() == 0) begin
                $display("%0t: unexpected command word: expected none, got pump_on=%0b group=%0d",
                         $time, pump_on, grp);
                errors++;
                return;
            end
            want = pending_cmds.pop_front();
            if (pump_on !== want.pump_on) begin
                $display("%0t: pump_on mismatch: expected %0b, got %0b",
                         $time, want.pump_on, pump_on);
                errors++;
            end
            if (grp !== want.grp_num) begin
                $display("%0t: group_number mismatch: expected %0d, got %0d",
                         $time, want.grp_num, grp);
                errors++;
            end
        endfunction

        function int pending();
            return pending_cmds.size();
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    int   src_gap_max = 8;
    int   sink_gap_max = 8;
    int   stall_cycles;
    pump_command_tracker tracker = new();

    hdp_cfg_if cfg_bus ();
    hdp_in_if  rep_bus ();
    hdp_out_if cmd_bus ();

    heat_demand_pump_hysteresis #(
        .ZONE_SLOTS(ZONES)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg  (cfg_bus),
        .i_in   (rep_bus),
        .o_out  (cmd_bus)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (cmd_bus.valid && cmd_bus.ready)
                tracker.match_command(cmd_bus.pump_on, cmd_bus.group_number);
            if (rep_bus.valid && rep_bus.ready)
                tracker.absorb_report(rep_bus.is_demand_report, rep_bus.zone_id,
                                      rep_bus.demand);
            if (cfg_bus.valid && cfg_bus.ready)
                tracker.write_reg(cfg_bus.index, cfg_bus.data);
        end
    end

    initial begin
        int hold;
        cmd_bus.ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            hold = $urandom_range(0, sink_gap_max);
            if (hold > 0) begin
                cmd_bus.ready <= 1'b0;
                repeat (hold) @(posedge i_clk);
            end
            cmd_bus.ready <= 1'b1;
            do @(posedge i_clk); while (!(cmd_bus.valid && cmd_bus.ready));
        end
    end

    initial begin
        stall_cycles = 0;
        while (stall_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((rep_bus.valid && rep_bus.ready) || (cmd_bus.valid && cmd_bus.ready) ||
                (cfg_bus.valid && cfg_bus.ready))
                stall_cycles = 0;
            else
                stall_cycles++;
        end
        $display("[heat_demand_pump_hysteresis] ERROR");
        $finish;
    end

    task automatic send_report(input logic is_report, input logic [ID_W-1:0] id,
                               input logic [DEM_W-1:0] dem);
        int gap;
        gap = $urandom_range(0, src_gap_max);
        if (gap > 0) begin
            rep_bus.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        rep_bus.valid <= 1'b1;
        rep_bus.is_demand_report <= is_report;
        rep_bus.zone_id <= id;
        rep_bus.demand <= dem;
        do @(posedge i_clk); while (!(rep_bus.valid && rep_bus.ready));
    endtask

    // Holds the report channel idle until every expected command word has arrived.
    task automatic drain_commands();
        rep_bus.valid <= 1'b0;
        do @(posedge i_clk); while (tracker.pending() != 0);
    endtask

    task automatic write_regs(input logic [CFG_DATA_W-1:0] on_v,
                              input logic [CFG_DATA_W-1:0] off_v,
                              input logic [CFG_DATA_W-1:0] grp_v);
        logic [CFG_IDX_W-1:0]  idx [4];
        logic [CFG_DATA_W-1:0] val [4];
        idx[0] = CFG_ON_THRESHOLD;
        val[0] = on_v;
        idx[1] = CFG_OFF_THRESHOLD;
        val[1] = off_v;
        idx[2] = CFG_PUMP_GROUP;
        val[2] = grp_v;
        idx[3] = CFG_UNUSED;
        val[3] = CFG_DATA_W'($urandom_range(0, 255));
        for (int k = 0; k < 4; k++) begin
            cfg_bus.valid <= 1'b1;
            cfg_bus.index <= idx[k];
            cfg_bus.data <= val[k];
            do @(posedge i_clk); while (!(cfg_bus.valid && cfg_bus.ready));
        end
        cfg_bus.valid <= 1'b0;
    endtask

    initial begin
        int counted;
        int pick;
        int dem_hi;
        logic [CFG_DATA_W-1:0] on_v;
        logic [CFG_DATA_W-1:0] off_v;
        logic [CFG_DATA_W-1:0] grp_v;
        logic [ID_W-1:0] id;
        logic [DEM_W-1:0] dem;

        i_rst_n <= 1'b0;
        rep_bus.valid <= 1'b0;
        rep_bus.is_demand_report <= 1'b0;
        rep_bus.zone_id <= '0;
        rep_bus.demand <= '0;
        cfg_bus.valid <= 1'b0;
        cfg_bus.index <= '0;
        cfg_bus.data <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed words under the reset thresholds.
        send_report(1'b0, 8'd0, 8'd0);
        send_report(1'b0, FREE_ID, 8'd255);
        send_report(1'b1, FREE_ID, 8'd200);
        send_report(1'b1, 8'd0, 8'd0);
        send_report(1'b1, 8'd254, 8'd255);
        send_report(1'b1, 8'd0, 8'd1);
        send_report(1'b1, 8'd254, 8'd0);
        send_report(1'b1, 8'd0, 8'd35);
        send_report(1'b1, 8'd1, 8'd65);
        send_report(1'b1, 8'd1, 8'd5);
        for (int k = 0; k < 13; k++)
            send_report(1'b1, ID_W'(19 * k + 2), (k % 3 == 0) ? 8'd0 : DEM_W'(10 * k + 7));
        send_report(1'b1, 8'd77, 8'd255);
        drain_commands();

        for (int p = 0; p < PHASES; p++) begin
            repeat (LATENCY_PAD) @(posedge i_clk);
            case (p)
                0: begin
                    on_v = 8'd255; off_v = 8'd0; grp_v = 8'd255;
                    dem_hi = 255; src_gap_max = 8; sink_gap_max = 8;
                end
                1: begin
                    on_v = 8'd0; off_v = 8'd255; grp_v = 8'd0;
                    dem_hi = 255; src_gap_max = 8; sink_gap_max = 0;
                end
                2: begin
                    on_v = 8'd120; off_v = 8'd60; grp_v = 8'hA5;
                    dem_hi = 255; src_gap_max = 0; sink_gap_max = 8;
                end
                3: begin
                    on_v = 8'd30; off_v = 8'd10; grp_v = 8'h5A;
                    dem_hi = 60; src_gap_max = 8; sink_gap_max = 8;
                end
                4: begin
                    on_v = CFG_DATA_W'($urandom_range(0, 255));
                    off_v = CFG_DATA_W'($urandom_range(0, 255));
                    grp_v = CFG_DATA_W'($urandom_range(0, 255));
                    dem_hi = $urandom_range(20, 255); src_gap_max = 0; sink_gap_max = 0;
                end
                default: begin
                    on_v = 8'd100; off_v = 8'd99; grp_v = 8'd1;
                    dem_hi = 255; src_gap_max = 3; sink_gap_max = 3;
                end
            endcase
            write_regs(on_v, off_v, grp_v);
            @(posedge i_clk);

            counted = 0;
            while (counted < ITEMS_PER_PHASE) begin
                pick = $urandom_range(0, 19);
                dem = ($urandom_range(0, 9) < 2) ? '0 : DEM_W'($urandom_range(0, dem_hi));
                if (pick == 0) begin
                    send_report(1'b0, ID_W'($urandom_range(0, 255)),
                                DEM_W'($urandom_range(0, 255)));
                end else if (pick == 1) begin
                    send_report(1'b1, FREE_ID, dem);
                end else begin
                    if (pick < 4)
                        id = ID_W'($urandom_range(0, 254));
                    else
                        id = tracker.slot_id[$urandom_range(0, ZONES - 1)];
                    send_report(1'b1, id, dem);
                    if (id != FREE_ID) counted++;
                end
                if ($urandom_range(0, 59) == 0) drain_commands();
            end
            drain_commands();
        end

        repeat (LATENCY_PAD) @(posedge i_clk);
        if (tracker.errors == 0 && tracker.pending() == 0)
            $display("[heat_demand_pump_hysteresis] OK");
        else
            $display("[heat_demand_pump_hysteresis] ERROR");
        $finish;
    end
endmodule

/* sim.f */
+incdir+src
src/hdp_pkg.sv
src/hdp_if.sv
src/hdp_ram.sv
src/heat_demand_pump_hysteresis.sv
verif/tb_heat_demand_pump_hysteresis.sv
